### design/garch_pkg.sv
// Shared types and constants for the GARCH(1,1) variance / log-likelihood core.
// Used by garch_ctrl, garch_dp and garch_variance_loglik_core; no dependencies.
`default_nettype none
package garch_pkg;

  localparam int unsigned VAR_FRAC_BITS_DEF = 32;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 48;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_INTERCEPT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ARCH_COEF = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GARCH_COEF = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_VAR = 3'd3;

  localparam logic [47:0] RST_INTERCEPT = 48'd4294967;
  localparam logic [47:0] RST_ARCH_COEF = 48'd429496730;
  localparam logic [47:0] RST_GARCH_COEF = 48'd3435973837;
  localparam logic [47:0] RST_INIT_VAR = 48'd4294967296;

  localparam logic [63:0] LN2_Q64 = 64'hB17217F7D1CF79AB;
  localparam logic [63:0] NONSTAT_SUM = 64'(100000) << 32;

  // datapath commands
  typedef enum logic [4:0] {
    DP_NOP,
    DP_LOAD,
    DP_MUL_SQP,
    DP_CAP_SQP,
    DP_MUL_T1,
    DP_CAP_T1,
    DP_MUL_T2,
    DP_CAP_T2,
    DP_MUL_TF,
    DP_CAP_TF,
    DP_NORM_INIT,
    DP_NORM_STEP,
    DP_MUL_LOG,
    DP_LOG_UPD,
    DP_MUL_LN,
    DP_CAP_LN,
    DP_MUL_SQX,
    DP_CAP_SQX,
    DP_DIV_INIT,
    DP_DIV_STEP,
    DP_FINISH
  } dp_cmd_t;

  // datapath status back to the controller
  typedef struct packed {
    logic mul_busy;
    logic norm_done;
    logic out_free;
    logic is_fcst;
    logic is_start;
    logic pending;
  } dp_status_t;

endpackage
`default_nettype wire

### design/garch_ctrl.sv
// Controller state machine: sequences the datapath through one item.
// Depends on garch_pkg.
`default_nettype none
module garch_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire garch_pkg::dp_status_t st,
  output garch_pkg::dp_cmd_t         cmd
);
  import garch_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_DECODE, S_SQP_W, S_T1, S_T1_W, S_T2, S_T2_W, S_TF_W,
    S_NORM_INIT, S_NORM, S_LOG_W, S_LOG_M, S_LN, S_LN_W, S_SQX, S_SQX_W,
    S_DIV_I, S_DIV, S_DONE
  } state_t;

  state_t     state_r, state_nxt;
  logic [6:0] cnt_r, cnt_nxt;

  assign in_ready = (state_r == S_IDLE);

  // next state and command
  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    cmd = DP_NOP;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd = DP_LOAD;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        if (st.is_fcst) begin
          if (st.pending) begin
            cmd = DP_MUL_SQP;
            state_nxt = S_SQP_W;
          end else begin
            cmd = DP_MUL_TF;
            state_nxt = S_TF_W;
          end
        end else if (st.is_start) begin
          state_nxt = S_DONE;
        end else begin
          cmd = DP_MUL_SQP;
          state_nxt = S_SQP_W;
        end
      end
      S_SQP_W: if (!st.mul_busy) begin
        cmd = DP_CAP_SQP;
        state_nxt = S_T1;
      end
      S_T1: begin
        cmd = DP_MUL_T1;
        state_nxt = S_T1_W;
      end
      S_T1_W: if (!st.mul_busy) begin
        cmd = DP_CAP_T1;
        state_nxt = S_T2;
      end
      S_T2: begin
        cmd = DP_MUL_T2;
        state_nxt = S_T2_W;
      end
      S_T2_W: if (!st.mul_busy) begin
        cmd = DP_CAP_T2;
        state_nxt = st.is_fcst ? S_DONE : S_NORM_INIT;
      end
      S_TF_W: if (!st.mul_busy) begin
        cmd = DP_CAP_TF;
        state_nxt = S_DONE;
      end
      S_NORM_INIT: begin
        cmd = DP_NORM_INIT;
        state_nxt = S_NORM;
      end
      S_NORM: begin
        if (st.norm_done) begin
          cmd = DP_MUL_LOG;
          cnt_nxt = 7'd31;
          state_nxt = S_LOG_W;
        end else begin
          cmd = DP_NORM_STEP;
        end
      end
      S_LOG_W: if (!st.mul_busy) begin
        cmd = DP_LOG_UPD;
        if (cnt_r == '0) begin
          state_nxt = S_LN;
        end else begin
          cnt_nxt = cnt_r - 7'd1;
          state_nxt = S_LOG_M;
        end
      end
      S_LOG_M: begin
        cmd = DP_MUL_LOG;
        state_nxt = S_LOG_W;
      end
      S_LN: begin
        cmd = DP_MUL_LN;
        state_nxt = S_LN_W;
      end
      S_LN_W: if (!st.mul_busy) begin
        cmd = DP_CAP_LN;
        state_nxt = S_SQX;
      end
      S_SQX: begin
        cmd = DP_MUL_SQX;
        state_nxt = S_SQX_W;
      end
      S_SQX_W: if (!st.mul_busy) begin
        cmd = DP_CAP_SQX;
        state_nxt = S_DIV_I;
      end
      S_DIV_I: begin
        cmd = DP_DIV_INIT;
        cnt_nxt = 7'd127;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd = DP_DIV_STEP;
        if (cnt_r == '0) state_nxt = S_DONE;
        else cnt_nxt = cnt_r - 7'd1;
      end
      S_DONE: if (st.out_free) begin
        cmd = DP_FINISH;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

### design/garch_dp.sv
// Datapath: config registers, filter state, shared 32x32 multiplier,
// log2 normalizer/squarer, restoring divider and the output register.
// Depends on garch_pkg.
`default_nettype none
module garch_dp #(
  parameter int unsigned VAR_FRAC_BITS = garch_pkg::VAR_FRAC_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_we,
  input  wire logic [garch_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [garch_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  wire logic                                in_req_type,
  input  wire logic                                in_series_start,
  input  wire logic signed [31:0]                  in_sample,
  input  wire garch_pkg::dp_cmd_t                  cmd,
  output garch_pkg::dp_status_t                    st,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [47:0]                              out_variance,
  output logic signed [63:0]                       out_loglik_sum,
  output logic                                     out_nonstationary,
  output logic                                     out_saturated
);
  import garch_pkg::*;

  localparam logic [48:0] ONE_VAR = 49'(1) << VAR_FRAC_BITS;
  localparam logic [127:0] LN_ONE_P = (128'(VAR_FRAC_BITS) << 32) * {64'd0, LN2_Q64};
  localparam logic [63:0] LN_ONE = LN_ONE_P[127:64];
  localparam logic [63:0] S64_MAX = 64'h7FFFFFFFFFFFFFFF;
  localparam logic [63:0] S64_MIN = 64'h8000000000000000;

  // config
  logic [47:0] a0_r, a1_r, b0_r, init_r;
  // filter state
  logic [31:0] prev_x_r;
  logic [47:0] prev_h_r;
  logic [63:0] sum_r;
  logic        pend_r;
  // item latch and work registers
  logic        fcst_r, start_r, sat_r;
  logic [31:0] x_r;
  logic [63:0] sq_r, x2_r, lnh_r;
  logic [47:0] t1_r, h_r;
  // multiplier
  logic [63:0]  ma_r, mb_r;
  logic [127:0] acc_r;
  logic [1:0]   mcnt_r;
  logic         mbusy_r;
  // log unit
  logic [63:0] m_r;
  logic [5:0]  p_r;
  logic [31:0] frac_r;
  // divider
  logic [127:0] num_r;
  logic [47:0]  rem_r;
  logic [63:0]  q_r;
  logic         over_r;
  // output
  logic        ov_r;
  logic [47:0] ovar_r;
  logic [63:0] osum_r;
  logic        ons_r, osat_r;

  function automatic logic [31:0] mag32(input logic [31:0] raw);
    mag32 = raw[31] ? (~raw + 32'd1) : raw;
  endfunction

  // saturating signed add: {sat, sum}
  function automatic logic [64:0] sadd(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) sadd = {1'b1, s[64] ? S64_MIN : S64_MAX};
    else sadd = {1'b0, s[63:0]};
  endfunction

  // multiplier partial product
  logic [31:0]  pa, pb;
  logic [63:0]  pp;
  logic [127:0] pp_sh;
  always_comb begin
    pa = mcnt_r[0] ? ma_r[63:32] : ma_r[31:0];
    pb = mcnt_r[1] ? mb_r[63:32] : mb_r[31:0];
    pp = 64'(pa) * 64'(pb);
    case (mcnt_r)
      2'd0: pp_sh = {64'd0, pp};
      2'd3: pp_sh = {pp, 64'd0};
      default: pp_sh = {32'd0, pp, 32'd0};
    endcase
  end

  // product scaling with clip to 48 bits
  logic [127:0] sh48, shf;
  logic         sat48, satf;
  assign sh48 = acc_r >> 48;
  assign shf = acc_r >> VAR_FRAC_BITS;
  assign sat48 = |sh48[127:48];
  assign satf = |shf[127:48];

  logic [47:0] t48, tf;
  assign t48 = sat48 ? '1 : sh48[47:0];
  assign tf = satf ? '1 : shf[47:0];

  logic [49:0] h3;
  assign h3 = {2'b0, a0_r} + {2'b0, t1_r} + {2'b0, tf};
  logic [49:0] h2;
  assign h2 = {2'b0, a0_r} + {2'b0, tf};

  logic [47:0] heff;
  assign heff = (h_r == '0) ? 48'd1 : h_r;

  // log squaring result
  logic [63:0] msq;
  assign msq = acc_r[125:62];

  // divider step
  logic [48:0] remsh;
  logic        ge;
  assign remsh = {rem_r, num_r[127]};
  assign ge = remsh >= {1'b0, heff};

  // finish arithmetic
  logic [63:0] qv;
  logic        qsat;
  logic [64:0] term, nsum;
  assign qsat = over_r | q_r[63];
  assign qv = qsat ? S64_MAX : q_r;
  assign term = sadd(qv, lnh_r);
  assign nsum = sadd(sum_r, term[63:0]);

  logic nonstat;
  assign nonstat = ({1'b0, a1_r} + {1'b0, b0_r}) > ONE_VAR;

  assign st.mul_busy = mbusy_r;
  assign st.norm_done = m_r[62];
  assign st.out_free = !ov_r || out_ready;
  assign st.is_fcst = fcst_r;
  assign st.is_start = start_r;
  assign st.pending = pend_r;

  assign out_valid = ov_r;
  assign out_variance = ovar_r;
  assign out_loglik_sum = osum_r;
  assign out_nonstationary = ons_r;
  assign out_saturated = osat_r;

  // control-type registers with reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a0_r <= RST_INTERCEPT;
      a1_r <= RST_ARCH_COEF;
      b0_r <= RST_GARCH_COEF;
      init_r <= RST_INIT_VAR;
      prev_x_r <= '0;
      prev_h_r <= '0;
      sum_r <= '0;
      pend_r <= 1'b0;
      mbusy_r <= 1'b0;
      mcnt_r <= '0;
      ov_r <= 1'b0;
    end else begin
      // config writes
      if (cfg_we) begin
        case (cfg_index)
          CFG_INTERCEPT: a0_r <= cfg_wdata;
          CFG_ARCH_COEF: a1_r <= cfg_wdata;
          CFG_GARCH_COEF: b0_r <= cfg_wdata;
          CFG_INIT_VAR: init_r <= cfg_wdata;
          default: ;
        endcase
      end
      // multiplier sequencing
      if (mbusy_r) begin
        mcnt_r <= mcnt_r + 2'd1;
        if (mcnt_r == 2'd3) mbusy_r <= 1'b0;
      end
      case (cmd)
        DP_MUL_SQP, DP_MUL_T1, DP_MUL_T2, DP_MUL_TF,
        DP_MUL_LOG, DP_MUL_LN, DP_MUL_SQX: begin
          mbusy_r <= 1'b1;
          mcnt_r <= '0;
        end
        default: ;
      endcase
      // commit step; a new result replaces one taken in the same cycle
      if (cmd == DP_FINISH) begin
        ov_r <= 1'b1;
        if (fcst_r) begin
          prev_h_r <= h_r;
          pend_r <= 1'b0;
        end else begin
          prev_x_r <= x_r;
          pend_r <= 1'b1;
          if (start_r) begin
            prev_h_r <= init_r;
            sum_r <= '0;
          end else begin
            prev_h_r <= h_r;
            sum_r <= nsum[63:0];
          end
        end
      end else if (ov_r && out_ready) begin
        // output handshake
        ov_r <= 1'b0;
      end
    end
  end

  // payload and work registers
  always_ff @(posedge clk) begin
    if (mbusy_r) acc_r <= acc_r + pp_sh;
    case (cmd)
      DP_LOAD: begin
        fcst_r <= in_req_type;
        start_r <= in_series_start;
        x_r <= in_sample;
        sat_r <= 1'b0;
      end
      DP_MUL_SQP: begin
        ma_r <= {32'd0, mag32(prev_x_r)};
        mb_r <= {32'd0, mag32(prev_x_r)};
        acc_r <= '0;
      end
      DP_CAP_SQP: sq_r <= acc_r[63:0];
      DP_MUL_T1: begin
        ma_r <= {16'd0, a1_r};
        mb_r <= sq_r;
        acc_r <= '0;
      end
      DP_CAP_T1: begin
        t1_r <= t48;
        if (sat48) sat_r <= 1'b1;
      end
      DP_MUL_T2: begin
        ma_r <= {16'd0, b0_r};
        mb_r <= {16'd0, prev_h_r};
        acc_r <= '0;
      end
      DP_CAP_T2: begin
        h_r <= (h3[49:48] != 2'b0) ? '1 : h3[47:0];
        if (satf || h3[49:48] != 2'b0) sat_r <= 1'b1;
      end
      DP_MUL_TF: begin
        ma_r <= 64'(a1_r) + 64'(b0_r);
        mb_r <= {16'd0, prev_h_r};
        acc_r <= '0;
      end
      DP_CAP_TF: begin
        h_r <= (h2[49:48] != 2'b0) ? '1 : h2[47:0];
        if (satf || h2[49:48] != 2'b0) sat_r <= 1'b1;
      end
      DP_NORM_INIT: begin
        // bit 47 of h lands on bit 62
        m_r <= {1'b0, heff, 15'd0};
        p_r <= 6'd47;
        frac_r <= '0;
      end
      DP_NORM_STEP: begin
        m_r <= m_r << 1;
        p_r <= p_r - 6'd1;
      end
      DP_MUL_LOG: begin
        ma_r <= m_r;
        mb_r <= m_r;
        acc_r <= '0;
      end
      DP_LOG_UPD: begin
        frac_r <= {frac_r[30:0], msq[63]};
        m_r <= msq[63] ? (msq >> 1) : msq;
      end
      DP_MUL_LN: begin
        ma_r <= {26'd0, p_r, frac_r};
        mb_r <= LN2_Q64;
        acc_r <= '0;
      end
      DP_CAP_LN: lnh_r <= acc_r[127:64] - LN_ONE;
      DP_MUL_SQX: begin
        ma_r <= {32'd0, mag32(x_r)};
        mb_r <= {32'd0, mag32(x_r)};
        acc_r <= '0;
      end
      DP_CAP_SQX: x2_r <= acc_r[63:0];
      DP_DIV_INIT: begin
        num_r <= {64'd0, x2_r} << (VAR_FRAC_BITS - 16);
        rem_r <= '0;
        q_r <= '0;
        over_r <= 1'b0;
      end
      DP_DIV_STEP: begin
        num_r <= num_r << 1;
        if (q_r[63]) over_r <= 1'b1;
        q_r <= {q_r[62:0], ge};
        rem_r <= ge ? 48'(remsh - {1'b0, heff}) : remsh[47:0];
      end
      DP_FINISH: begin
        ons_r <= nonstat;
        if (fcst_r) begin
          ovar_r <= h_r;
          osum_r <= nonstat ? NONSTAT_SUM : sum_r;
          osat_r <= sat_r;
        end else if (start_r) begin
          ovar_r <= init_r;
          osum_r <= nonstat ? NONSTAT_SUM : '0;
          osat_r <= 1'b0;
        end else begin
          ovar_r <= h_r;
          osum_r <= nonstat ? NONSTAT_SUM : nsum[63:0];
          osat_r <= sat_r | qsat | term[64] | nsum[64];
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

### design/garch_variance_loglik_core.sv
// Top level of the GARCH(1,1) variance / log-likelihood core.
// Depends on garch_pkg, garch_ctrl and garch_dp.
//
//   channel | ports                                                | direction
//   input   | in_valid/in_ready, req_type, series_start, sample    | in
//   result  | out_valid/out_ready, variance, sum, flags            | out
//   config  | cfg_we, cfg_index, cfg_wdata                         | in
//
// One item at a time. A series start is only latched and committed; a
// forecast tick forms one product, or the full recursion for the first tick
// after samples. An observed sample runs the recursion (each 64x64 product
// on the shared 32x32 multiplier), normalization, 32 log2 squarings, ln and
// x^2, the 128-step divider and the commit. Reset (rst_n, sync) clears the
// filter state and loads register defaults. A stalled result sits in the
// output register while the next item is accepted and worked; that item
// waits at commit until it is taken.
`default_nettype none
module garch_variance_loglik_core #(
  parameter int unsigned VAR_FRAC_BITS = garch_pkg::VAR_FRAC_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [garch_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [garch_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic                              in_req_type,
  input  wire logic                              in_series_start,
  input  wire logic signed [31:0]                in_sample,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [47:0]                            out_variance,
  output logic signed [63:0]                     out_loglik_sum,
  output logic                                   out_nonstationary,
  output logic                                   out_saturated
);
  import garch_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t st;

  garch_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  garch_dp #(
    .VAR_FRAC_BITS (VAR_FRAC_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_req_type       (in_req_type),
    .in_series_start   (in_series_start),
    .in_sample         (in_sample),
    .cmd               (cmd),
    .st                (st),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_variance      (out_variance),
    .out_loglik_sum    (out_loglik_sum),
    .out_nonstationary (out_nonstationary),
    .out_saturated     (out_saturated)
  );

endmodule
`default_nettype wire

### sim/garch_variance_loglik_core_tb.sv
// Self-checking testbench for garch_variance_loglik_core: random-idle valid/ready traffic,
// scoreboard class predicts variance, log-likelihood sum and flags for every transfer.
// Depends on garch_pkg and the core RTL only.
`timescale 1ns / 1ps

module garch_variance_loglik_core_tb;
  import garch_pkg::*;

  localparam int unsigned FRAC = VAR_FRAC_BITS_DEF;
  localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;
  localparam logic [63:0] SUM_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] SUM_MIN = 64'h8000_0000_0000_0000;
  localparam logic [63:0] ONE_H = 64'd1 << FRAC;
  localparam longint unsigned CYCLE_LIMIT = 64'd4_000_000;
  localparam int N_PHASES = 8;
  localparam int ITEMS_PER_PHASE = 180;

  typedef struct packed {
    logic [47:0] variance;
    logic [63:0] loglik_sum;
    logic nonstationary;
    logic saturated;
  } garch_result_t;

  // Scoreboard: shadow copy of filter state, queue of predicted results
  class garch_scoreboard;
    logic [47:0] a0, a1, b0, h_init;
    logic [31:0] last_x;
    logic [47:0] last_h;
    logic [63:0] loglik;
    bit x_pending;
    garch_result_t expected_q[$];
    int errors;

    function void clear();
      a0 = RST_INTERCEPT; a1 = RST_ARCH_COEF; b0 = RST_GARCH_COEF; h_init = RST_INIT_VAR;
      last_x = '0; last_h = '0; loglik = '0; x_pending = 0;
      expected_q.delete();
      errors = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [47:0] val);
      case (idx)
        CFG_INTERCEPT:  a0 = val;
        CFG_ARCH_COEF:  a1 = val;
        CFG_GARCH_COEF: b0 = val;
        CFG_INIT_VAR:   h_init = val;
        default: ;
      endcase
    endfunction

    // floor(a*b >> s), clipped to 48 bits
    function logic [47:0] mul_shift(logic [63:0] a, logic [63:0] b, int s, inout bit sat);
      logic [127:0] p;
      p = ({64'd0, a} * {64'd0, b}) >> s;
      if (p > {80'd0, MAX48}) begin
        sat = 1;
        return MAX48;
      end
      return p[47:0];
    endfunction

    function logic [47:0] add3(logic [47:0] x, logic [47:0] y, logic [47:0] z, inout bit sat);
      logic [49:0] r;
      r = {2'b0, x} + {2'b0, y} + {2'b0, z};
      if (r > {2'b0, MAX48}) begin
        sat = 1;
        return MAX48;
      end
      return r[47:0];
    endfunction

    function logic [63:0] sq_mag(logic [31:0] raw);
      logic [63:0] mag;
      mag = raw[31] ? (64'd1 << 32) - {32'd0, raw} : {32'd0, raw};
      return mag * mag;
    endfunction

    // log2 by repeated squaring, Q.32
    function logic [63:0] log2_q32(logic [63:0] u);
      int p;
      logic [63:0] m, fr;
      logic [127:0] sq;
      p = 0;
      while (p < 62 && (u >> (p + 1)) != 0) p++;
      m = u << (62 - p);
      fr = '0;
      for (int i = 0; i < 32; i++) begin
        sq = {64'd0, m} * {64'd0, m};
        m = sq[125:62];
        fr = fr << 1;
        if (m[63]) begin
          fr[0] = 1'b1;
          m = m >> 1;
        end
      end
      return (64'(p) << 32) | fr;
    endfunction

    function logic [63:0] ln_q32(logic [63:0] u);
      logic [127:0] p;
      p = {64'd0, log2_q32(u)} * {64'd0, LN2_Q64};
      return p[127:64];
    endfunction

    function logic [63:0] sat_add(logic [63:0] x, logic [63:0] y, inout bit sat);
      logic signed [64:0] s;
      s = $signed({x[63], x}) + $signed({y[63], y});
      if (s > $signed({1'b0, SUM_MAX})) begin
        sat = 1;
        return SUM_MAX;
      end
      if (s < $signed({1'b1, SUM_MIN})) begin
        sat = 1;
        return SUM_MIN;
      end
      return s[63:0];
    endfunction

    function logic [47:0] recur_h(inout bit sat);
      logic [47:0] t1, t2;
      t1 = mul_shift({16'd0, a1}, sq_mag(last_x), 48, sat);
      t2 = mul_shift({16'd0, b0}, {16'd0, last_h}, FRAC, sat);
      return add3(a0, t1, t2, sat);
    endfunction

    // Work out the result of one accepted transfer
    function void note_input(bit fcst, bit start, logic [31:0] x);
      garch_result_t r;
      bit sat, nonstat;
      logic [47:0] h, heff;
      logic [63:0] lnh, term, x2;
      logic [127:0] q;
      sat = 0;
      nonstat = ({16'd0, a1} + {16'd0, b0}) > ONE_H;
      if (!fcst) begin
        if (start) begin
          h = h_init;
          loglik = '0;
        end else begin
          h = recur_h(sat);
          heff = (h == 0) ? 48'd1 : h;
          lnh = ln_q32({16'd0, heff}) - ln_q32(ONE_H);
          x2 = sq_mag(x);
          q = ({64'd0, x2} << (FRAC - 16)) / {80'd0, heff};
          if (q >= (128'd1 << 63)) begin
            sat = 1;
            term = SUM_MAX;
          end else begin
            term = q[63:0];
          end
          term = sat_add(term, lnh, sat);
          loglik = sat_add(loglik, term, sat);
        end
        last_x = x;
        x_pending = 1;
      end else if (x_pending) begin
        h = recur_h(sat);
        x_pending = 0;
      end else begin
        h = add3(a0, mul_shift({16'd0, a1} + {16'd0, b0}, {16'd0, last_h}, FRAC, sat),
                 48'd0, sat);
      end
      last_h = h;
      r.variance = h;
      r.loglik_sum = nonstat ? NONSTAT_SUM : loglik;
      r.nonstationary = nonstat;
      r.saturated = sat;
      expected_q.push_back(r);
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
      errors++;
    endtask

    task check_result(garch_result_t got);
      garch_result_t want;
      if (expected_q.size() == 0) begin
        report("unexpected transfer", 64'(got.variance), 64'd0);
        return;
      end
      want = expected_q.pop_front();
      if (got.variance !== want.variance)
        report("variance", 64'(got.variance), 64'(want.variance));
      if (got.loglik_sum !== want.loglik_sum)
        report("loglik_sum", got.loglik_sum, want.loglik_sum);
      if (got.nonstationary !== want.nonstationary)
        report("nonstationary", 64'(got.nonstationary), 64'(want.nonstationary));
      if (got.saturated !== want.saturated)
        report("saturated", 64'(got.saturated), 64'(want.saturated));
    endtask
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic in_valid = 0;
  logic in_ready;
  logic in_req_type = 0;
  logic in_series_start = 0;
  logic signed [31:0] in_sample = '0;
  logic out_valid;
  logic out_ready = 0;
  logic [47:0] out_variance;
  logic signed [63:0] out_loglik_sum;
  logic out_nonstationary;
  logic out_saturated;

  garch_scoreboard variance_sb;
  longint unsigned cycles = 0;
  bit in_burst = 0;
  bit out_burst = 0;

  garch_variance_loglik_core dut (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_wdata,
    .in_valid, .in_ready, .in_req_type, .in_series_start, .in_sample,
    .out_valid, .out_ready, .out_variance, .out_loglik_sum,
    .out_nonstationary, .out_saturated
  );

  always #5 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("garch_variance_loglik_core_tb NOT OK");
      $finish;
    end
  end

  // Config write, only while the core is idle
  task cfg_write(logic [CFG_IDX_W-1:0] idx, logic [47:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    variance_sb.set_reg(idx, val);
    cfg_we <= 0;
    @(posedge clk);
  endtask

  // Send one item; returns just after the accepting edge
  task send_item(bit fcst, bit start, logic [31:0] x);
    int gap;
    gap = in_burst ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_req_type <= fcst;
    in_series_start <= start;
    in_sample <= x;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    variance_sb.note_input(fcst, start, x);
  endtask

  function logic [31:0] rand_sample();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $urandom_range(0, 32'h0200_0000) ^ {32{$urandom_range(0, 1) == 1}};
      2: return $urandom_range(0, 32'h0020_0000) ^ {32{$urandom_range(0, 1) == 1}};
      default: return $urandom_range(0, 32'h1000_0000) ^ {32{$urandom_range(0, 1) == 1}};
    endcase
  endfunction

  // Mostly well-formed series (start, samples, forecast runs); some noise
  task rand_item();
    int r;
    r = $urandom_range(0, 99);
    if (r < 6) send_item(0, 1, rand_sample());
    else if (r < 72) send_item(0, 0, rand_sample());
    else if (r < 94) send_item(1, 0, rand_sample());
    else send_item(1, 1, $urandom);
  endtask

  // Drop valid after the last transfer and drain all results
  task wait_idle();
    in_valid <= 0;
    while (variance_sb.expected_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  // Result side: random stalls, check each transfer
  initial begin
    garch_result_t got;
    int stall, n;
    n = 0;
    @(posedge rst_n);
    forever begin
      if (n % 40 == 0) out_burst = ($urandom_range(0, 3) == 0);
      stall = out_burst ? 0 : $urandom_range(0, 16);
      if (stall > 0) begin
        out_ready <= 0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1;
      do @(negedge clk); while (!out_valid);
      got = '{out_variance, out_loglik_sum, out_nonstationary, out_saturated};
      @(posedge clk);
      variance_sb.check_result(got);
      n++;
    end
  end

  // Main sequence
  initial begin
    logic [47:0] regs [4];
    variance_sb = new();
    variance_sb.clear();
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: forecasts from reset, sample extremes, series restarts
    send_item(1, 0, 32'h0);
    send_item(1, 1, 32'hFFFF_FFFF);
    send_item(0, 0, 32'h0100_0000);
    send_item(0, 1, 32'h8000_0000);
    send_item(0, 0, 32'h7FFF_FFFF);
    send_item(0, 0, 32'h8000_0000);
    send_item(0, 0, 32'h0000_0000);
    send_item(0, 0, 32'hFFFF_FFFF);
    send_item(0, 0, 32'h0000_0001);
    send_item(1, 0, 32'h1234_5678);
    send_item(1, 0, 32'h0);
    send_item(1, 1, 32'h0);
    send_item(0, 0, 32'hFF00_0000);
    send_item(0, 1, 32'h0100_0000);
    send_item(0, 0, 32'h0080_0000);
    wait_idle();

    // extremes: everything at max gives clipping and the nonstationary flag
    cfg_write(CFG_INTERCEPT, MAX48);
    cfg_write(CFG_ARCH_COEF, MAX48);
    cfg_write(CFG_GARCH_COEF, MAX48);
    cfg_write(CFG_INIT_VAR, MAX48);
    cfg_write(3'd5, 48'd7);
    send_item(0, 1, 32'h7FFF_FFFF);
    send_item(0, 0, 32'h8000_0000);
    send_item(0, 0, 32'h0000_0001);
    send_item(1, 0, 32'h0);
    send_item(1, 0, 32'h0);
    wait_idle();

    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0: regs = '{48'd1, 48'd0, 48'd0, 48'd1};
        1: regs = '{RST_INTERCEPT, 48'h8000_0000, 48'h8000_0001, RST_INIT_VAR};
        2: regs = '{RST_INTERCEPT, 48'h8000_0000, 48'h8000_0000, RST_INIT_VAR};
        3: regs = '{RST_INTERCEPT, RST_ARCH_COEF, RST_GARCH_COEF, RST_INIT_VAR};
        4: regs = '{MAX48, 48'd0, 48'hFFFF_FFFF, MAX48};
        default: regs = '{48'($urandom_range(1, 32'hFFFF_FFFF)),
                          48'($urandom_range(0, 32'hFFFF_FFFF)) << $urandom_range(0, 1),
                          48'($urandom_range(0, 32'hFFFF_FFFF)),
                          {16'($urandom_range(0, 32'hFFFF)), 32'($urandom) | 32'd1}};
      endcase
      for (int i = 0; i < 4; i++) cfg_write(i[CFG_IDX_W-1:0], regs[i]);
      send_item(0, 1, rand_sample());
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        if (k % 30 == 0) in_burst = ($urandom_range(0, 3) == 0);
        rand_item();
      end
      wait_idle();
    end

    repeat (50) @(posedge clk);
    if (variance_sb.errors == 0 && variance_sb.expected_q.size() == 0) begin
      $display("garch_variance_loglik_core_tb OK");
    end else begin
      $display("garch_variance_loglik_core_tb NOT OK");
    end
    $finish;
  end

endmodule
